### hw/rtl/qoi_pkg.sv
// Shared types, opcodes and sizes for the QOI-style RGB pixel encoder.
// Used by qoi_front, qoi_back and the top level; depends on nothing.
`default_nettype none
package qoi_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int FIFO_DEPTH_DEF    = 4;

	localparam int PX_W     = 24;
	localparam int BUNDLE_N = 5;
	localparam int CNT_W    = 3;

	localparam logic [7:0] OPC_RGB   = 8'hFE;
	localparam logic [7:0] OPC_INDEX = 8'h00;
	localparam logic [7:0] OPC_DIFF  = 8'h40;
	localparam logic [7:0] OPC_LUMA  = 8'h80;
	localparam logic [7:0] OPC_RUN   = 8'hC0;

	// A run is written out once it reaches this length.
	localparam logic [5:0] RUN_LIMIT = 6'd62;
	localparam logic [5:0] RUN_MAX_HELD = RUN_LIMIT - 6'd1;

	// Alpha is fixed at 255 and only the low six bits of the hash matter.
	localparam int HASH_BIAS = (255 * 11) % 64;

	// The opcode bytes that one pixel produces, first byte in the top bits.
	typedef struct packed {
		logic [8*BUNDLE_N-1:0] bytes;
		logic [CNT_W-1:0]      count;
		logic                  last;
	} bundle_t;

	localparam int BUNDLE_W = $bits(bundle_t);

endpackage
`default_nettype wire

### hw/rtl/qoi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module qoi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/qoi_fifo.sv
// Small register queue of opcode bundles between the classifier and the byte serializer.
// Depends on nothing but its parameters.
`default_nettype none
module qoi_fifo #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic      [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/qoi_front.sv
// Front end: accepts pixels, looks them up in the color table and builds opcode bundles.
// Depends on qoi_pkg and qoi_ram.
`default_nettype none
module qoi_front #(
	parameter int TABLE_ENTRIES = qoi_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic            cfg_wdata,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      red,
	input  wire logic [7:0]      green,
	input  wire logic [7:0]      blue,
	input  wire logic [7:0]      ref_red,
	input  wire logic [7:0]      ref_green,
	input  wire logic [7:0]      ref_blue,
	input  wire logic            end_of_frame,
	output logic                 push,
	output qoi_pkg::bundle_t     push_bundle,
	input  wire logic            fifo_full
);
	import qoi_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_ENTRIES);

	logic                color_difference_q;
	logic [PX_W-1:0]     last_q;
	logic [5:0]          run_q;
	logic [TABLE_ENTRIES-1:0] tbl_vld_q;

	logic                valid_s1;
	logic [PX_W-1:0]     px_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                eof_s1;
	logic                fwd_s1;

	logic                accept;
	logic                retire;
	logic [7:0]          r_in;
	logic [7:0]          g_in;
	logic [7:0]          b_in;
	logic [PX_W-1:0]     px_in;
	logic [11:0]         hash_sum;
	logic [SLOT_W-1:0]   slot_in;
	logic [PX_W-1:0]     rd_data;
	logic [PX_W-1:0]     entry;
	logic                same;
	logic                hit;
	logic                tbl_we;
	logic [5:0]          run_next;

	logic [7:0]          pr;
	logic [7:0]          pg;
	logic [7:0]          pb;
	logic signed [7:0]   dr;
	logic signed [7:0]   dg;
	logic signed [7:0]   db;
	logic signed [7:0]   rr;
	logic signed [7:0]   rb;
	logic [7:0]          dr_b;
	logic [7:0]          dg_b;
	logic [7:0]          db_b;
	logic [7:0]          dg_l;
	logic [7:0]          rr_l;
	logic [7:0]          rb_l;
	logic                is_diff;
	logic                is_luma;
	logic [31:0]         main_bytes;
	logic [CNT_W-1:0]    main_cnt;
	bundle_t             bundle;

	// Pixel as coded, optionally reference minus current per channel.
	assign r_in  = color_difference_q ? ref_red   - red   : red;
	assign g_in  = color_difference_q ? ref_green - green : green;
	assign b_in  = color_difference_q ? ref_blue  - blue  : blue;
	assign px_in = {r_in, g_in, b_in};

	assign hash_sum = 12'(r_in) * 12'd3 + 12'(g_in) * 12'd5 + 12'(b_in) * 12'd7
		+ 12'(HASH_BIAS);
	assign slot_in = hash_sum[SLOT_W-1:0];

	assign accept   = in_valid && in_ready;
	assign retire   = valid_s1 && ((bundle.count == '0) || !fifo_full);
	assign in_ready = !valid_s1 || retire;
	assign push     = valid_s1 && (bundle.count != '0) && !fifo_full;
	assign push_bundle = bundle;

	assign tbl_we = retire && !same && !hit;

	qoi_ram #(
		.WIDTH (PX_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (slot_in),
		.rdata (rd_data)
	);

	// The item ahead may have written this slot in the cycle of the read; its
	// pixel is then the last pixel. A cleared table reads as black.
	assign entry = tbl_vld_q[slot_s1] ? (fwd_s1 ? last_q : rd_data) : '0;
	assign same  = (px_s1 == last_q);
	assign hit   = (entry == px_s1);

	assign pr = last_q[23:16];
	assign pg = last_q[15:8];
	assign pb = last_q[7:0];
	assign dr = px_s1[23:16] - pr;
	assign dg = px_s1[15:8]  - pg;
	assign db = px_s1[7:0]   - pb;
	assign rr = dr - dg;
	assign rb = db - dg;

	assign is_diff = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
		&& (db >= -8'sd2) && (db <= 8'sd1);
	assign is_luma = (dg >= -8'sd32) && (dg <= 8'sd31) && (rr >= -8'sd8) && (rr <= 8'sd7)
		&& (rb >= -8'sd8) && (rb <= 8'sd7);

	assign dr_b = dr + 8'd2;
	assign dg_b = dg + 8'd2;
	assign db_b = db + 8'd2;
	assign dg_l = dg + 8'd32;
	assign rr_l = rr + 8'd8;
	assign rb_l = rb + 8'd8;

	always_comb begin
		if (hit) begin
			main_bytes = {OPC_INDEX | 8'(slot_s1), 24'd0};
			main_cnt   = CNT_W'(1);
		end else if (is_diff) begin
			main_bytes = {OPC_DIFF | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]}, 24'd0};
			main_cnt   = CNT_W'(1);
		end else if (is_luma) begin
			main_bytes = {OPC_LUMA | {2'b00, dg_l[5:0]}, rr_l[3:0], rb_l[3:0], 16'd0};
			main_cnt   = CNT_W'(2);
		end else begin
			main_bytes = {OPC_RGB, px_s1};
			main_cnt   = CNT_W'(4);
		end
	end

	always_comb begin
		bundle.last = eof_s1;
		run_next    = '0;
		if (same) begin
			// A repeat extends the run; it is written once full or at frame end.
			if (run_q == RUN_MAX_HELD || eof_s1) begin
				bundle.bytes = {OPC_RUN | {2'b00, run_q}, 32'd0};
				bundle.count = CNT_W'(1);
			end else begin
				bundle.bytes = '0;
				bundle.count = '0;
				run_next     = run_q + 6'd1;
			end
		end else if (run_q != '0) begin
			bundle.bytes = {OPC_RUN | {2'b00, run_q - 6'd1}, main_bytes};
			bundle.count = main_cnt + CNT_W'(1);
		end else begin
			bundle.bytes = {main_bytes, 8'd0};
			bundle.count = main_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_difference_q <= 1'b0;
			last_q             <= '0;
			run_q              <= '0;
			tbl_vld_q          <= '0;
			valid_s1           <= 1'b0;
			fwd_s1             <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_difference_q <= cfg_wdata;
			end
			if (retire) begin
				if (eof_s1) begin
					last_q    <= '0;
					run_q     <= '0;
					tbl_vld_q <= '0;
				end else begin
					last_q <= px_s1;
					run_q  <= run_next;
					if (tbl_we) begin
						tbl_vld_q[slot_s1] <= 1'b1;
					end
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= tbl_we && (slot_in == slot_s1);
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px_in;
			slot_s1 <= slot_in;
			eof_s1  <= end_of_frame;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) run_q <= RUN_MAX_HELD)
		else $error("run length exceeds the longest run held between pixels");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && eof_s1 |-> bundle.count != '0)
		else $error("end-of-frame pixel produced no bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		retire && eof_s1 |=> run_q == '0 && last_q == '0 && tbl_vld_q == '0)
		else $error("state not cleared after end of frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && same |-> bundle.count <= CNT_W'(1))
		else $error("repeated pixel produced more than one byte");

endmodule
`default_nettype wire

### hw/rtl/qoi_back.sv
// Back end: takes opcode bundles from the queue and sends them out one byte per transaction.
// Depends on qoi_pkg.
`default_nettype none
module qoi_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  qoi_pkg::bundle_t head_bundle,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last_byte
);
	import qoi_pkg::*;

	logic [8*BUNDLE_N-1:0] cur_bytes_q;
	logic [CNT_W-1:0]      cur_left_q;
	logic                  cur_last_q;
	logic                  done;

	assign out_valid = (cur_left_q != '0);
	assign out_byte  = cur_bytes_q[8*BUNDLE_N-1 -: 8];
	assign last_byte = cur_last_q && (cur_left_q == CNT_W'(1));

	// The holding register frees up when it is empty or its final byte leaves.
	assign done = (cur_left_q == '0) || (out_ready && cur_left_q == CNT_W'(1));
	assign pop  = done && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_left_q <= '0;
			cur_last_q <= 1'b0;
		end else if (pop) begin
			cur_left_q <= head_bundle.count;
			cur_last_q <= head_bundle.last;
		end else if (done) begin
			cur_left_q <= '0;
		end else if (out_ready) begin
			cur_left_q <= cur_left_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= head_bundle.bytes;
		end else if (out_ready && out_valid) begin
			cur_bytes_q <= {cur_bytes_q[8*BUNDLE_N-9:0], 8'd0};
		end
	end

endmodule
`default_nettype wire

### hw/rtl/qoi_rgb_pixel_encoder.sv
// QOI-style RGB opcode encoder, top level; depends on qoi_pkg, qoi_front, qoi_fifo, qoi_back.
// Throughput: one pixel per cycle while pixels yield at most one byte and out_ready holds;
// the output port moves one byte per cycle while out_ready is high and bytes are waiting.
// Reset clears all state at once: color table valid bits, last pixel, run, queue and
// the color_difference register; there is no clearing pass.
`default_nettype none
module qoi_rgb_pixel_encoder #(
	parameter int TABLE_ENTRIES = qoi_pkg::TABLE_ENTRIES_DEF,
	parameter int FIFO_DEPTH    = qoi_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] ref_red,
	input  wire logic [7:0] ref_green,
	input  wire logic [7:0] ref_blue,
	input  wire logic       end_of_frame,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_byte
);
	import qoi_pkg::*;

	logic    push;
	bundle_t push_bundle;
	logic    fifo_full;
	logic    pop;
	logic    head_valid;
	bundle_t head_bundle;

	qoi_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.ref_red      (ref_red),
		.ref_green    (ref_green),
		.ref_blue     (ref_blue),
		.end_of_frame (end_of_frame),
		.push         (push),
		.push_bundle  (push_bundle),
		.fifo_full    (fifo_full)
	);

	qoi_fifo #(
		.WIDTH (BUNDLE_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_bundle),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_bundle)
	);

	qoi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_bundle (head_bundle),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

endmodule
`default_nettype wire

### sim/tb_qoi_rgb_pixel_encoder.sv
// Self-checking testbench for qoi_rgb_pixel_encoder: drives pixel transactions, predicts
// the opcode bytes of each one and compares every output transaction against them.
// Depends on qoi_pkg and the encoder RTL.
module tb_qoi_rgb_pixel_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import qoi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} opcode_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] ref_red;
	logic [7:0] ref_green;
	logic [7:0] ref_blue;
	logic       end_of_frame;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       last_byte;

	// Predictor state.
	rgb_t       color_tbl[64];
	rgb_t       prev_px;
	logic [5:0] run_len;
	logic       diff_mode;

	opcode_byte_t expected_bytes[$];

	// Stimulus control.
	rgb_t seen_px[16];
	int   seen_wr;
	int   run_left;
	bit   no_gaps;
	bit   rx_free;
	int   rx_hold_request;
	int   n_fail;
	int   cycles;

	qoi_rgb_pixel_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.ref_red(ref_red),
		.ref_green(ref_green),
		.ref_blue(ref_blue),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_byte(last_byte)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic clear_encoder_state();
		foreach (color_tbl[i]) color_tbl[i] = '0;
		prev_px = '0;
		run_len = '0;
	endtask

	// Works out the opcode bytes that one accepted pixel produces.
	task automatic encode_pixel(input rgb_t cur, input rgb_t refp, input logic eof);
		rgb_t              px;
		logic [5:0]        slot;
		logic signed [7:0] dr, dg, db, rr, rb;
		logic [7:0]        codes[$];
		opcode_byte_t      rec;
		px = cur;
		if (diff_mode) begin
			px.r = refp.r - cur.r;
			px.g = refp.g - cur.g;
			px.b = refp.b - cur.b;
		end
		if (px == prev_px) begin
			run_len++;
			if (run_len == RUN_LIMIT) begin
				codes.push_back(OPC_RUN | 8'(run_len - 6'd1));
				run_len = '0;
			end
		end else begin
			if (run_len != 0) begin
				codes.push_back(OPC_RUN | 8'(run_len - 6'd1));
				run_len = '0;
			end
			slot = 6'(3 * px.r + 5 * px.g + 7 * px.b + HASH_BIAS);
			if (color_tbl[slot] == px) begin
				codes.push_back(OPC_INDEX | 8'(slot));
			end else begin
				color_tbl[slot] = px;
				dr = px.r - prev_px.r;
				dg = px.g - prev_px.g;
				db = px.b - prev_px.b;
				rr = dr - dg;
				rb = db - dg;
				if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
					codes.push_back(OPC_DIFF | 8'((dr + 2) << 4) | 8'((dg + 2) << 2)
						| 8'(db + 2));
				end else if (dg >= -32 && dg <= 31 && rr >= -8 && rr <= 7
						&& rb >= -8 && rb <= 7) begin
					codes.push_back(OPC_LUMA | 8'(dg + 32));
					codes.push_back(8'(((rr + 8) << 4) | (rb + 8)));
				end else begin
					codes.push_back(OPC_RGB);
					codes.push_back(px.r);
					codes.push_back(px.g);
					codes.push_back(px.b);
				end
			end
			prev_px = px;
		end
		if (eof) begin
			if (run_len != 0)
				codes.push_back(OPC_RUN | 8'(run_len - 6'd1));
			clear_encoder_state();
		end
		foreach (codes[i]) begin
			rec.code = codes[i];
			rec.last = eof && (i == codes.size() - 1);
			expected_bytes.push_back(rec);
		end
	endtask

	always @(posedge clk) begin
		opcode_byte_t exp_rec;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected output transaction: out_byte %02h last_byte %0b",
					out_byte, last_byte);
				n_fail++;
			end else begin
				exp_rec = expected_bytes.pop_front();
				if (out_byte !== exp_rec.code) begin
					$error("out_byte: expected %02h, actual %02h", exp_rec.code, out_byte);
					n_fail++;
				end
				if (last_byte !== exp_rec.last) begin
					$error("last_byte: expected %0b, actual %0b", exp_rec.last, last_byte);
					n_fail++;
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Output side: a requested hold-off wins over the random stalls.
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				stall = rx_hold_request;
				rx_hold_request = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_free)
					stall = pick_gap();
			end
		end
	end

	function automatic rgb_t rand_rgb();
		return rgb_t'($urandom_range(0, 24'hFFFFFF));
	endfunction

	task automatic send_pixel(input rgb_t cur, input rgb_t refp, input logic eof);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		red          <= cur.r;
		green        <= cur.g;
		blue         <= cur.b;
		ref_red      <= refp.r;
		ref_green    <= refp.g;
		ref_blue     <= refp.b;
		end_of_frame <= eof;
		do @(posedge clk); while (!in_ready);
		encode_pixel(cur, refp, eof);
	endtask

	// Drops valid and waits until every predicted byte has come out, then lets the
	// pipeline settle since a pixel that only extends a run produces nothing.
	task automatic drain_encoder();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_color_difference(input logic value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
		diff_mode = value;
	endtask

	// Picks the pixel the encoder should see after the optional difference step.
	function automatic rgb_t next_coded_pixel();
		rgb_t px;
		int   roll;
		int   dgl;
		if (run_left > 0) begin
			run_left--;
			return prev_px;
		end
		roll = $urandom_range(0, 99);
		px = prev_px;
		if (roll < 5) begin
			run_left = $urandom_range(55, 70);
		end else if (roll < 25) begin
			px = prev_px;
		end else if (roll < 45) begin
			px.r = prev_px.r + 8'($urandom_range(0, 3) - 2);
			px.g = prev_px.g + 8'($urandom_range(0, 3) - 2);
			px.b = prev_px.b + 8'($urandom_range(0, 3) - 2);
		end else if (roll < 65) begin
			dgl = $urandom_range(0, 63) - 32;
			px.g = prev_px.g + 8'(dgl);
			px.r = prev_px.r + 8'(dgl + $urandom_range(0, 15) - 8);
			px.b = prev_px.b + 8'(dgl + $urandom_range(0, 15) - 8);
		end else if (roll < 80) begin
			px = seen_px[$urandom_range(0, 15)];
		end else if (roll < 84) begin
			px = ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
		end else begin
			px = rand_rgb();
		end
		return px;
	endfunction

	// Sends a pixel whose coded value is the given one, in either register setting.
	task automatic send_coded(input rgb_t coded, input logic eof);
		rgb_t refp;
		rgb_t cur;
		refp = rand_rgb();
		cur = coded;
		if (diff_mode) begin
			cur.r = refp.r - coded.r;
			cur.g = refp.g - coded.g;
			cur.b = refp.b - coded.b;
		end
		send_pixel(cur, refp, eof);
		seen_px[seen_wr] = coded;
		seen_wr = (seen_wr + 1) % 16;
	endtask

	task automatic test_directed_opcodes();
		write_color_difference(1'b0);
		send_pixel(24'h000000, 24'hFFFFFF, 1'b0);  // black equals the reset pixel: a run
		send_pixel(24'h0100FF, rand_rgb(), 1'b0);  // run flush, then DIFF
		send_pixel(24'h181415, rand_rgb(), 1'b0);  // LUMA
		send_pixel(24'hFFFFFF, rand_rgb(), 1'b0);  // LUMA across the wrap
		send_pixel(24'hC80064, rand_rgb(), 1'b0);  // full RGB
		send_pixel(24'h000000, rand_rgb(), 1'b0);  // black hits an untouched slot
		send_pixel(24'hC80064, rand_rgb(), 1'b0);  // INDEX
		send_pixel(24'hC80064, rand_rgb(), 1'b0);
		send_pixel(24'hC80064, rand_rgb(), 1'b0);
		send_pixel(24'h0080FF, rand_rgb(), 1'b0);  // run flush plus RGB: five bytes
		send_pixel(24'h0080FF, rand_rgb(), 1'b1);  // end of frame flushes the run
		send_pixel(24'h000000, rand_rgb(), 1'b1);  // single black pixel frame
		send_pixel(24'hFF0000, rand_rgb(), 1'b1);  // last flag on a one-byte DIFF
		send_pixel(24'h00FF00, rand_rgb(), 1'b1);
		drain_encoder();
		write_color_difference(1'b1);
		send_pixel(24'h010101, 24'h000000, 1'b0);
		send_pixel(24'h000000, 24'hFFFFFF, 1'b0);
		send_pixel(24'hFFFFFF, 24'hFFFFFF, 1'b0);
		send_pixel(24'h804020, 24'h00FF80, 1'b1);
		drain_encoder();
		write_color_difference(1'b0);
	endtask

	// A run that reaches the limit is written at once and restarts from zero.
	task automatic test_run_limit();
		send_pixel(24'h070707, rand_rgb(), 1'b0);
		repeat (62) send_pixel(24'h070707, rand_rgb(), 1'b0);
		repeat (3) send_pixel(24'h070707, rand_rgb(), 1'b0);
		send_pixel(24'h070707, rand_rgb(), 1'b1);
		drain_encoder();
	endtask

	// The output side holds off while pixels keep coming, so the queue fills up.
	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_hold_request = 300;
		repeat (39) send_pixel(rand_rgb(), rand_rgb(), 1'b0);
		send_pixel(rand_rgb(), rand_rgb(), 1'b1);
		no_gaps = 1'b0;
		drain_encoder();
	endtask

	task automatic test_random_frames(input int n_items);
		int   sent;
		int   len;
		int   i;
		logic eof;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			for (i = 0; i < len && sent < n_items; i++) begin
				eof = (i == len - 1) || (sent == n_items - 1) || ($urandom_range(0, 39) == 0);
				send_coded(next_coded_pixel(), eof);
				sent++;
			end
		end
		drain_encoder();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		ref_red = '0;
		ref_green = '0;
		ref_blue = '0;
		end_of_frame = 1'b0;
		diff_mode = 1'b0;
		no_gaps = 1'b0;
		rx_free = 1'b0;
		rx_hold_request = 0;
		run_left = 0;
		seen_wr = 0;
		n_fail = 0;
		cycles = 0;
		foreach (seen_px[i]) seen_px[i] = rand_rgb();
		clear_encoder_state();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_directed_opcodes();
		test_run_limit();
		test_backpressure();
		test_random_frames(45);
		write_color_difference(1'b1);
		no_gaps = 1'b1;
		rx_free = 1'b1;
		test_random_frames(45);
		no_gaps = 1'b0;
		rx_free = 1'b0;
		test_random_frames(25);
		write_color_difference(1'b0);
		test_random_frames(30);

		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
